FILE: sv/utf8_stream_sanitizer_assert.svh
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_assert.svh
// Assertion macros shared by the UTF-8 stream sanitizer.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_SANITIZER_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define UTF8S_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_stream_sanitizer: assertion failed");

// Next-cycle implication, disabled during reset
`define UTF8S_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_stream_sanitizer: assertion failed");

`endif

FILE: sv/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types and constants shared by the UTF-8 stream sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    // Most result beats one input beat can cause
    localparam int MaxResults = 4;
    // Held bytes of an unfinished sequence
    localparam int HoldDepth  = 3;

    localparam logic [7:0] ReplChar = 8'h3F;
    localparam logic [7:0] LeadC0   = 8'hC0;
    localparam logic [7:0] LeadC1   = 8'hC1;

    // Group of result bytes produced by one input beat
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [MaxResults-1:0]      repl;
        logic [2:0]                 n;
        logic                       last;
    } grp_t;

    // Serialiser status seen by the top level
    typedef struct packed {
        logic [2:0] pend;
        logic       out_full;
    } stat_t;

endpackage

FILE: sv/utf8s_if.sv
// ----------------------------------------------------------------------------
// utf8s_if
// Valid/ready channels of the sanitizer: raw byte input and cleaned output.
// ----------------------------------------------------------------------------
interface utf8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface utf8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_replaced;
    logic       out_run_end;
    logic       out_stream_end;

    modport source (output valid, output out_byte, output out_replaced,
                    output out_run_end, output out_stream_end, input ready);
    modport sink   (input valid, input out_byte, input out_replaced,
                    input out_run_end, input out_stream_end, output ready);
endinterface

FILE: sv/utf8s_decode.sv
// ----------------------------------------------------------------------------
// utf8s_decode
// Holds the partial sequence and turns each accepted byte into a group of
// zero to four result bytes.
// ----------------------------------------------------------------------------
module utf8s_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output utf8s_pkg::grp_t   grp
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [2:0] len_reg;
    logic [2:0] len_next;
    logic [utf8s_pkg::HoldDepth-1:0][7:0] pb_reg;

    logic       cont;
    logic       complete;
    logic       extend;
    logic       cutoff;
    logic [2:0] flen;
    logic       tail_valid;
    logic       tail_repl;
    logic [7:0] tail_byte;
    logic       hold_new;

    // Classify the byte against the held sequence
    always_comb
    begin
        cont     = (in_byte[7:6] == 2'b10);
        complete = (cnt_reg != 2'd0) && cont && (({1'b0, cnt_reg} + 3'd1) == len_reg);
        extend   = (cnt_reg != 2'd0) && cont && !complete && !in_last;
        cutoff   = (cnt_reg != 2'd0) && cont && !complete && in_last;

        if (in_byte[7:5] == 3'b110)
            flen = 3'd2;
        else if (in_byte[7:4] == 4'b1110)
            flen = 3'd3;
        else if (in_byte[7:3] == 5'b11110)
            flen = 3'd4;
        else
            flen = 3'd0;

        hold_new   = 1'b0;
        tail_valid = 1'b1;
        tail_repl  = 1'b0;
        tail_byte  = in_byte;
        if (complete)
        begin
            tail_repl = 1'b0;
        end
        else if (cutoff)
        begin
            tail_repl = 1'b1;
            tail_byte = utf8s_pkg::ReplChar;
        end
        else if (extend)
        begin
            tail_valid = 1'b0;
        end
        else if (!in_byte[7])
        begin
            tail_repl = 1'b0;
        end
        else if (in_byte == utf8s_pkg::LeadC0 || in_byte == utf8s_pkg::LeadC1 ||
                 flen == 3'd0 || in_last)
        begin
            tail_repl = 1'b1;
            tail_byte = utf8s_pkg::ReplChar;
        end
        else
        begin
            tail_valid = 1'b0;
            hold_new   = 1'b1;
        end
    end

    // Build the result group: held bytes (or their replacements), then the tail
    always_comb
    begin
        grp = '0;
        for (int i = 0; i < utf8s_pkg::HoldDepth; i++)
        begin
            if (i < int'(cnt_reg))
            begin
                grp.bytes[i] = complete ? pb_reg[i] : utf8s_pkg::ReplChar;
                grp.repl[i]  = !complete;
            end
        end
        for (int i = 0; i < utf8s_pkg::MaxResults; i++)
        begin
            if (i == int'(cnt_reg))
            begin
                grp.bytes[i] = tail_byte;
                grp.repl[i]  = tail_repl;
            end
        end
        grp.n    = extend ? 3'd0 : ({1'b0, cnt_reg} + {2'b00, tail_valid});
        grp.last = in_last;
    end

    // Next held-sequence state
    always_comb
    begin
        cnt_next = 2'd0;
        len_next = 3'd0;
        if (extend)
        begin
            cnt_next = cnt_reg + 2'd1;
            len_next = len_reg;
        end
        else if (hold_new)
        begin
            cnt_next = 2'd1;
            len_next = flen;
        end
    end

    // Advance control state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            len_reg <= 3'd0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    // Store the held bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (hold_new)
                pb_reg[0] <= in_byte;
            for (int i = 1; i < utf8s_pkg::HoldDepth; i++)
            begin
                if (extend && i == int'(cnt_reg))
                    pb_reg[i] <= in_byte;
            end
        end
    end

endmodule

FILE: sv/utf8s_serial.sv
// ----------------------------------------------------------------------------
// utf8s_serial
// Holds a result group and hands it out one beat at a time through an
// output register.
// ----------------------------------------------------------------------------
module utf8s_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  utf8s_pkg::grp_t   grp,
    output logic              in_ready,
    output utf8s_pkg::stat_t  stat,
    utf8s_out_if.source       clean
);

    logic [2:0] cnt_reg;
    logic [utf8s_pkg::MaxResults-1:0][7:0] byte_reg;
    logic [utf8s_pkg::MaxResults-1:0]      repl_reg;
    logic       last_reg;
    logic       valid_reg;
    logic [7:0] obyte_reg;
    logic       orepl_reg;
    logic       orun_reg;
    logic       ostream_reg;

    logic       out_free;
    logic       move;

    // Output register is free when empty or being taken this cycle
    always_comb
    begin
        out_free = !valid_reg || clean.ready;
        move     = (cnt_reg != 3'd0) && out_free;
        in_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_free);
        stat.pend     = cnt_reg;
        stat.out_full = valid_reg;
    end

    // Group count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                cnt_reg <= grp.n;
            else if (move)
                cnt_reg <= cnt_reg - 3'd1;

            if (move)
                valid_reg <= 1'b1;
            else if (clean.ready)
                valid_reg <= 1'b0;
        end
    end

    // Load or shift the group
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= grp.bytes;
            repl_reg <= grp.repl;
            last_reg <= grp.last;
        end
        else if (move)
        begin
            for (int i = 0; i < utf8s_pkg::MaxResults - 1; i++)
            begin
                byte_reg[i] <= byte_reg[i+1];
                repl_reg[i] <= repl_reg[i+1];
            end
        end
    end

    // Advance the head of the group into the output register
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            obyte_reg   <= byte_reg[0];
            orepl_reg   <= repl_reg[0];
            orun_reg    <= (cnt_reg == 3'd1);
            ostream_reg <= (cnt_reg == 3'd1) && last_reg;
        end
    end

    assign clean.valid          = valid_reg;
    assign clean.out_byte       = obyte_reg;
    assign clean.out_replaced   = orepl_reg;
    assign clean.out_run_end    = orun_reg;
    assign clean.out_stream_end = ostream_reg;

endmodule

FILE: sv/utf8_stream_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Cleans a byte stream to well-formed UTF-8 lead/continuation structure.
// ----------------------------------------------------------------------------
// Channels: raw takes one byte beat with a last-of-stream flag; clean gives
// cleaned byte beats, each flagged as a replacement '?', as the end of the
// results of its input beat, and as the end of the stream.
// ASCII passes through; a 2-, 3- or 4-byte sequence is held until complete
// and then sent whole; broken, stray or cut-off bytes become '?' each.
// Path: a result passes through the group buffer and then the output
// register. An input beat that only extends a held sequence gives
// no result.
// Throughput: one input beat per cycle while each beat gives at most one
// result and the receiver is ready; a beat with more results (up to four)
// holds the group until all have moved out, and input stalls meanwhile.
// Group buffer and output register let a new beat in while a result waits.
// Reset clears the held sequence, the group buffer and the output register.
// When the receiver stalls, the output beat holds, the group stays, and raw
// is accepted only while the group is empty or about to drain.
// ----------------------------------------------------------------------------
`include "utf8_stream_sanitizer_assert.svh"

module utf8_stream_sanitizer (
    input  logic        clk,
    input  logic        rst_n,
    utf8s_in_if.sink    raw,
    utf8s_out_if.source clean
);

    utf8s_pkg::grp_t  grp;
    utf8s_pkg::stat_t stat;
    logic             accept;
    logic             load;
    logic             ready;

    // Accept a beat and load its group if it produced any result
    assign accept    = raw.valid && ready;
    assign load      = accept && (grp.n != 3'd0);
    assign raw.ready = ready;

    utf8s_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (raw.in_byte),
        .in_last (raw.in_last),
        .grp     (grp)
    );

    utf8s_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .grp      (grp),
        .in_ready (ready),
        .stat     (stat),
        .clean    (clean)
    );

    `UTF8S_ASSERT_IMP(a_pend_range, clk, rst_n, 1'b1, stat.pend <= 3'd4)
    `UTF8S_ASSERT_IMP(a_ready_drained, clk, rst_n, ready, stat.pend <= 3'd1)
    `UTF8S_ASSERT_IMP(a_stream_end_run, clk, rst_n, clean.valid && clean.out_stream_end,
                      clean.out_run_end)
    `UTF8S_ASSERT_NXT(a_group_loaded, clk, rst_n, load, stat.pend == $past(grp.n))

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UTF-8 stream sanitizer. A directed table covers the byte
// extremes, stray and forbidden leads, every sequence length, broken and
// cut-off sequences, followed by mostly well-formed random text with noise.
// Each accepted raw beat is run through a local model of the cleaner and the
// clean beats are compared in order with its results. Both channels idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;
    localparam int TailCycles = 20;
    localparam int HoldOffLen = 400;
    localparam int RandBeats  = 234;
    localparam int DirRows    = 26;

    // One result beat of the clean channel
    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       run_end;
        logic       stream_end;
    } clean_beat_t;

    // One raw beat, with its single result typed in where fixed is set
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        logic [7:0] fix_data;
        logic       fix_repl;
    } raw_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    utf8s_in_if  raw_ch ();
    utf8s_out_if clean_ch ();

    utf8_stream_sanitizer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_ch),
        .clean (clean_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Directed table: extremes, forbidden and stray bytes, all lengths,
    // broken and cut-off sequences
    raw_row_t dir_table [DirRows] = '{
        '{8'h00, 1'b0, 1'b1, 8'h00,               1'b0},
        '{8'h7F, 1'b0, 1'b1, 8'h7F,               1'b0},
        '{8'hC0, 1'b0, 1'b1, utf8s_pkg::ReplChar, 1'b1},
        '{8'hC1, 1'b0, 1'b1, utf8s_pkg::ReplChar, 1'b1},
        '{8'h80, 1'b0, 1'b1, utf8s_pkg::ReplChar, 1'b1},
        '{8'hFF, 1'b0, 1'b1, utf8s_pkg::ReplChar, 1'b1},
        '{8'hF8, 1'b0, 1'b1, utf8s_pkg::ReplChar, 1'b1},
        '{8'hC2, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hE0, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hA0, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hF7, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hBF, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hE1, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h41, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hE1, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hC3, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hA9, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'hF0, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h90, 1'b0, 1'b0, 8'h00,               1'b0},
        '{8'h80, 1'b1, 1'b0, 8'h00,               1'b0},
        '{8'h41, 1'b1, 1'b1, 8'h41,               1'b0}
    };

    raw_row_t    stim [$];
    clean_beat_t expected_q [$];
    int          taken_cnt = 0;
    int          got_cnt   = 0;
    int          err_cnt   = 0;
    int          cycle_cnt = 0;

    // Model state: held lead and continuations, their count, sequence length
    logic [7:0] held_bytes [utf8s_pkg::HoldDepth];
    logic [1:0] held_cnt = '0;
    logic [2:0] seq_len  = '0;

    // Turn every held byte into a replacement and go idle
    function automatic void drop_held(ref clean_beat_t grp[$]);
        for (int k = 0; k < held_cnt; k++)
            grp.push_back('{utf8s_pkg::ReplChar, 1'b1, 1'b0, 1'b0});
        held_cnt = '0;
        seq_len  = '0;
    endfunction

    // Handle a byte with nothing held
    function automatic void start_seq(ref clean_beat_t grp[$], input logic [7:0] b,
                                      input logic last);
        logic [2:0] len;
        len = '0;
        if (b < 8'h80)
        begin
            grp.push_back('{b, 1'b0, 1'b0, 1'b0});
            return;
        end
        if (b == utf8s_pkg::LeadC0 || b == utf8s_pkg::LeadC1)
        begin
            grp.push_back('{utf8s_pkg::ReplChar, 1'b1, 1'b0, 1'b0});
            return;
        end
        if ((b & 8'hE0) == 8'hC0)
            len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            len = 3'd4;
        if (len == 3'd0 || last)
        begin
            grp.push_back('{utf8s_pkg::ReplChar, 1'b1, 1'b0, 1'b0});
            return;
        end
        held_bytes[0] = b;
        held_cnt      = 2'd1;
        seq_len       = len;
    endfunction

    // Work out the clean beats caused by one raw beat
    function automatic void sanitize_byte(input logic [7:0] b, input logic last,
                                          ref clean_beat_t grp[$]);
        grp = {};
        if (held_cnt == 0)
        begin
            seq_len = '0;
            start_seq(grp, b, last);
        end
        else if (seq_len < 2 || seq_len > 4 || held_cnt >= seq_len)
        begin
            drop_held(grp);
            start_seq(grp, b, last);
        end
        else if ((b & 8'hC0) == 8'h80)
        begin
            if (held_cnt + 1 == seq_len)
            begin
                for (int k = 0; k < held_cnt; k++)
                    grp.push_back('{held_bytes[k], 1'b0, 1'b0, 1'b0});
                grp.push_back('{b, 1'b0, 1'b0, 1'b0});
                held_cnt = '0;
                seq_len  = '0;
            end
            else if (last)
            begin
                drop_held(grp);
                grp.push_back('{utf8s_pkg::ReplChar, 1'b1, 1'b0, 1'b0});
            end
            else
            begin
                held_bytes[held_cnt] = b;
                held_cnt = held_cnt + 2'd1;
            end
        end
        else
        begin
            drop_held(grp);
            start_seq(grp, b, last);
        end
        if (last)
        begin
            held_cnt = '0;
            seq_len  = '0;
        end
        // Mark the end of this beat's run
        if (grp.size() > 0)
        begin
            grp[grp.size()-1].run_end    = 1'b1;
            grp[grp.size()-1].stream_end = last;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void add_beat(input logic [7:0] b);
        stim.push_back('{b, ($urandom_range(24, 0) == 0), 1'b0, 8'h00, 1'b0});
    endfunction

    // Predict on each raw beat, then check each clean beat
    always @(posedge clk)
    begin
        clean_beat_t grp [$];
        clean_beat_t want;
        if (rst_n && raw_ch.valid && raw_ch.ready)
        begin
            sanitize_byte(raw_ch.in_byte, raw_ch.in_last, grp);
            if (stim[taken_cnt].fixed)
            begin
                want = '{stim[taken_cnt].fix_data, stim[taken_cnt].fix_repl, 1'b1,
                         raw_ch.in_last};
                grp  = {want};
            end
            foreach (grp[k])
                expected_q.push_back(grp[k]);
            taken_cnt++;
        end
        if (rst_n && clean_ch.valid && clean_ch.ready)
        begin
            got_cnt++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %h/%b/%b/%b",
                         $time, clean_ch.out_byte, clean_ch.out_replaced,
                         clean_ch.out_run_end, clean_ch.out_stream_end);
                err_cnt++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("out_byte", want.data, clean_ch.out_byte);
                check_field("out_replaced", {7'd0, want.repl}, {7'd0, clean_ch.out_replaced});
                check_field("out_run_end", {7'd0, want.run_end},
                            {7'd0, clean_ch.out_run_end});
                check_field("out_stream_end", {7'd0, want.stream_end},
                            {7'd0, clean_ch.out_stream_end});
            end
        end
    end

    // Give up on a hang
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit)
        begin
            $display("%0t: timeout", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int  stall;
        bit  held_off;
        held_off = 1'b0;
        clean_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && got_cnt >= 120)
            begin
                held_off = 1'b1;
                clean_ch.ready <= 1'b0;
                repeat (HoldOffLen) @(posedge clk);
            end
            stall = ((got_cnt / 60) % 3 == 1) ? 0 : $urandom_range(12, 0);
            if (stall > 0)
            begin
                clean_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            clean_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!clean_ch.valid);
        end
    end

    // Sender: build the stimulus, release reset, drive beats, finish
    initial
    begin
        int         kind;
        int         len;
        int         conts;
        int         gap;
        logic [7:0] b;
        raw_ch.valid   <= 1'b0;
        raw_ch.in_byte <= '0;
        raw_ch.in_last <= 1'b0;

        foreach (dir_table[r])
            stim.push_back(dir_table[r]);

        // Mostly well-formed text with random content, some broken, some noise
        while (stim.size() < DirRows + RandBeats)
        begin
            kind = $urandom_range(9, 0);
            if (kind <= 2)
                add_beat(8'($urandom_range(8'h7F, 8'h00)));
            else if (kind <= 7)
            begin
                len = $urandom_range(4, 2);
                if (len == 2)
                    add_beat(8'($urandom_range(8'hDF, 8'hC2)));
                else if (len == 3)
                    add_beat(8'($urandom_range(8'hEF, 8'hE0)));
                else
                    add_beat(8'($urandom_range(8'hF7, 8'hF0)));
                // A broken sequence stops short and then gets a non-continuation
                conts = (kind == 7) ? $urandom_range(len - 2, 0) : len - 1;
                for (int k = 0; k < conts; k++)
                    add_beat(8'h80 | 8'($urandom_range(63, 0)));
                if (kind == 7)
                begin
                    do
                        b = 8'($urandom_range(255, 0));
                    while (b[7:6] == 2'b10);
                    add_beat(b);
                end
            end
            else
                add_beat(8'($urandom_range(255, 0)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim[i])
        begin
            gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(12, 0);
            if (gap > 0)
            begin
                raw_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            raw_ch.valid   <= 1'b1;
            raw_ch.in_byte <= stim[i].data;
            raw_ch.in_last <= stim[i].last;
            do
                @(posedge clk);
            while (!raw_ch.ready);
        end
        raw_ch.valid <= 1'b0;

        // Let the last beat reach the model, drain, then watch for strays
        do
            @(posedge clk);
        while (expected_q.size() != 0);
        repeat (TailCycles) @(posedge clk);

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/utf8s_pkg.sv
sv/utf8s_if.sv
sv/utf8s_decode.sv
sv/utf8s_serial.sv
sv/utf8_stream_sanitizer.sv
sim/tb_top.sv
